>>> hdl/asccu_pkg.sv
`default_nettype none

package asccu_pkg;

    // Event kinds carried in func
    typedef enum logic [1:0] {
        FUNC_CMD   = 2'd0,
        FUNC_STEP  = 2'd1,
        FUNC_LIMIT = 2'd2,
        FUNC_TICK  = 2'd3
    } func_t;

    // Motion mode, also the visible run_mode
    typedef enum logic [1:0] {
        MODE_STOPPED = 2'd0,
        MODE_MOVING  = 2'd1,
        MODE_BACKOFF = 2'd2
    } mode_t;

    typedef logic        [7:0]  cmd_t;
    typedef logic        [1:0]  axis_t;
    typedef logic        [2:0]  limit_t;
    typedef logic        [2:0]  axis_bits_t;
    typedef logic signed [15:0] count_t;
    typedef logic        [14:0] end_count_t;
    typedef logic        [7:0]  pwm_ticks_t;
    typedef logic        [15:0] backoff_t;

    // Command codes
    localparam cmd_t CMD_SEL_BASE     = 8'd100;
    localparam cmd_t CMD_SEL_SHOULDER = 8'd101;
    localparam cmd_t CMD_SEL_ELBOW    = 8'd102;
    localparam cmd_t CMD_FORWARD      = 8'd103;
    localparam cmd_t CMD_BACKWARD     = 8'd104;
    localparam cmd_t CMD_OPEN         = 8'd105;
    localparam cmd_t CMD_CLOSE        = 8'd106;
    localparam cmd_t CMD_STOP         = 8'd109;

    // Axis numbers
    localparam axis_t AXIS_BASE     = 2'd0;
    localparam axis_t AXIS_SHOULDER = 2'd1;
    localparam axis_t AXIS_ELBOW    = 2'd2;

    // Limit switch patterns
    localparam limit_t LIM_ELBOW_FRONT    = 3'd4;
    localparam limit_t LIM_ELBOW_REAR     = 3'd3;
    localparam limit_t LIM_SHOULDER_REAR  = 3'd1;
    localparam limit_t LIM_SHOULDER_FRONT = 3'd5;
    localparam limit_t LIM_BASE_LEFT      = 3'd2;
    localparam limit_t LIM_BASE_RIGHT     = 3'd6;

    // Configuration register map (word index)
    localparam int CFG_ADDR_W = 5;
    localparam logic [2:0] REG_BASE_END     = 3'd0;
    localparam logic [2:0] REG_SHOULDER_END = 3'd1;
    localparam logic [2:0] REG_ELBOW_END    = 3'd2;
    localparam logic [2:0] REG_OPEN_HIGH    = 3'd3;
    localparam logic [2:0] REG_OPEN_LOW     = 3'd4;
    localparam logic [2:0] REG_CLOSED_HIGH  = 3'd5;
    localparam logic [2:0] REG_CLOSED_LOW   = 3'd6;
    localparam logic [2:0] REG_BACKOFF      = 3'd7;

    // Register reset values
    localparam end_count_t RST_BASE_END     = 15'd11700;
    localparam end_count_t RST_SHOULDER_END = 15'd8020;
    localparam end_count_t RST_ELBOW_END    = 15'd6700;
    localparam pwm_ticks_t RST_OPEN_HIGH    = 8'd5;
    localparam pwm_ticks_t RST_OPEN_LOW     = 8'd35;
    localparam pwm_ticks_t RST_CLOSED_HIGH  = 8'd2;
    localparam pwm_ticks_t RST_CLOSED_LOW   = 8'd38;
    localparam backoff_t   RST_BACKOFF      = 16'd800;

endpackage

`default_nettype wire

>>> hdl/asccu_if.sv
`default_nettype none

// Event channel
interface asccu_in_if;
    logic                  valid;
    logic                  ready;
    asccu_pkg::func_t      func;
    asccu_pkg::cmd_t       cmd_byte;
    asccu_pkg::axis_t      step_axis;
    asccu_pkg::limit_t     limit_code;

    modport source (output valid, output func, output cmd_byte, output step_axis,
                    output limit_code, input ready);
    modport sink   (input valid, input func, input cmd_byte, input step_axis,
                    input limit_code, output ready);
endinterface

// Status channel
interface asccu_out_if;
    logic                  valid;
    logic                  ready;
    logic                  base_dir;
    logic                  dir_shoulder;
    logic                  dir_elbow;
    asccu_pkg::axis_bits_t step_enables;
    asccu_pkg::count_t     base_count;
    asccu_pkg::count_t     shoulder_count;
    asccu_pkg::count_t     elbow_count;
    logic                  gripper_out;
    asccu_pkg::mode_t      run_mode;
    asccu_pkg::axis_t      chosen_axis;

    modport source (output valid, output base_dir, output dir_shoulder, output dir_elbow,
                    output step_enables, output base_count, output shoulder_count,
                    output elbow_count, output gripper_out, output run_mode,
                    output chosen_axis, input ready);
    modport sink   (input valid, input base_dir, input dir_shoulder, input dir_elbow,
                    input step_enables, input base_count, input shoulder_count,
                    input elbow_count, input gripper_out, input run_mode,
                    input chosen_axis, output ready);
endinterface

`default_nettype wire

>>> hdl/arm_stepper_command_controller_unit.sv
// Three-axis stepper arm controller with servo gripper.
// cmd_in carries one event per beat: a command byte, a completed step pulse,
// a limit-switch hit or a timer tick. res_out returns one status beat per
// event: direction pins, step enables, the three signed position counts,
// the gripper PWM level, the run mode and the selected axis.
// An event beat is captured in an input register and applied to the state
// registers when the status slot is free or being taken; the state registers
// drive res_out directly, and res_out.valid is set as the event is applied.
// Throughput is one event per cycle while res_out does not stall.
// When res_out stalls, the status holds, the input register keeps one more
// event, and cmd_in.ready drops once that register is full.
// The APB port writes the end counts, gripper high/low times and back-off
// length (registers at 4-byte steps); pready is always high and reads return
// the stored value. Registers are to be written only while no event is in
// flight. Reset clears the mode, directions, enables, counts and gripper
// state, and loads the register defaults; no clearing pass is needed.
`default_nettype none

module arm_stepper_command_controller_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    asccu_in_if.sink                               cmd_in,
    asccu_out_if.source                            res_out,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [asccu_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                       pwdata,
    output logic      [31:0]                       prdata,
    output logic                                   pready
);
    import asccu_pkg::*;

    // Configuration registers
    end_count_t base_end_reg, shoulder_end_reg, elbow_end_reg;
    pwm_ticks_t open_high_reg, open_low_reg, closed_high_reg, closed_low_reg;
    backoff_t   backoff_len_reg;

    // Input register
    logic       in_valid_reg;
    func_t      func_reg;
    cmd_t       cmd_reg;
    axis_t      step_axis_reg;
    limit_t     limit_reg;

    // Controller state (also the result register)
    logic       out_valid_reg, out_valid_next;
    mode_t      mode_reg, mode_next;
    axis_t      axis_reg, axis_next;
    logic       sense_reg, sense_next;
    axis_bits_t dir_reg, dir_next;
    axis_bits_t en_reg, en_next;
    count_t     cnt_reg [3];
    count_t     cnt_next [3];
    logic       gclosed_reg, gclosed_next;
    logic       glevel_reg, glevel_next;
    logic       glow_reg, glow_next;
    pwm_ticks_t gcount_reg, gcount_next;
    backoff_t   backoff_reg, backoff_next;

    logic       advance;
    logic       cfg_write;
    logic [2:0] cfg_sel;

    assign cfg_sel   = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    // Config write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_end_reg     <= RST_BASE_END;
            shoulder_end_reg <= RST_SHOULDER_END;
            elbow_end_reg    <= RST_ELBOW_END;
            open_high_reg    <= RST_OPEN_HIGH;
            open_low_reg     <= RST_OPEN_LOW;
            closed_high_reg  <= RST_CLOSED_HIGH;
            closed_low_reg   <= RST_CLOSED_LOW;
            backoff_len_reg  <= RST_BACKOFF;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                REG_BASE_END:     base_end_reg     <= pwdata[14:0];
                REG_SHOULDER_END: shoulder_end_reg <= pwdata[14:0];
                REG_ELBOW_END:    elbow_end_reg    <= pwdata[14:0];
                REG_OPEN_HIGH:    open_high_reg    <= pwdata[7:0];
                REG_OPEN_LOW:     open_low_reg     <= pwdata[7:0];
                REG_CLOSED_HIGH:  closed_high_reg  <= pwdata[7:0];
                REG_CLOSED_LOW:   closed_low_reg   <= pwdata[7:0];
                REG_BACKOFF:      backoff_len_reg  <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    // Config read-back
    always_comb
    begin
        case (cfg_sel)
            REG_BASE_END:     prdata = {17'd0, base_end_reg};
            REG_SHOULDER_END: prdata = {17'd0, shoulder_end_reg};
            REG_ELBOW_END:    prdata = {17'd0, elbow_end_reg};
            REG_OPEN_HIGH:    prdata = {24'd0, open_high_reg};
            REG_OPEN_LOW:     prdata = {24'd0, open_low_reg};
            REG_CLOSED_HIGH:  prdata = {24'd0, closed_high_reg};
            REG_CLOSED_LOW:   prdata = {24'd0, closed_low_reg};
            REG_BACKOFF:      prdata = {16'd0, backoff_len_reg};
            default:          prdata = 32'd0;
        endcase
    end

    // Handshake: apply the held event when the status slot is free or leaving
    assign advance      = in_valid_reg && (!out_valid_reg || res_out.ready);
    assign cmd_in.ready = !in_valid_reg || advance;

    always_comb
    begin
        if (advance)
            out_valid_next = 1'b1;
        else if (res_out.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (cmd_in.ready)
            in_valid_reg <= cmd_in.valid;
    end

    // Input payload
    always_ff @(posedge clk)
    begin
        if (cmd_in.valid && cmd_in.ready)
        begin
            func_reg      <= cmd_in.func;
            cmd_reg       <= cmd_in.cmd_byte;
            step_axis_reg <= cmd_in.step_axis;
            limit_reg     <= cmd_in.limit_code;
        end
    end

    // Event decode and next state
    always_comb
    begin
        logic       run_pwm;
        pwm_ticks_t hi_ticks;
        pwm_ticks_t lo_ticks;

        mode_next    = mode_reg;
        axis_next    = axis_reg;
        sense_next   = sense_reg;
        dir_next     = dir_reg;
        en_next      = en_reg;
        cnt_next     = cnt_reg;
        gclosed_next = gclosed_reg;
        glevel_next  = glevel_reg;
        glow_next    = glow_reg;
        gcount_next  = gcount_reg;
        backoff_next = backoff_reg;
        run_pwm      = 1'b1;

        if (mode_reg == MODE_BACKOFF)
        begin
            // only ticks matter while backing off
            if (func_reg == FUNC_TICK)
            begin
                if (gcount_reg != 8'hFF)
                    gcount_next = gcount_reg + 8'd1;
                if (backoff_reg <= 16'd1)
                begin
                    backoff_next = '0;
                    en_next      = '0;
                    mode_next    = MODE_STOPPED;
                end
                else
                begin
                    backoff_next = backoff_reg - 16'd1;
                    run_pwm      = 1'b0;
                end
            end
            else
                run_pwm = 1'b0;
        end
        else
        begin
            case (func_reg)
                FUNC_CMD:
                begin
                    case (cmd_reg)
                        CMD_SEL_BASE:     axis_next = AXIS_BASE;
                        CMD_SEL_SHOULDER: axis_next = AXIS_SHOULDER;
                        CMD_SEL_ELBOW:    axis_next = AXIS_ELBOW;
                        CMD_FORWARD, CMD_BACKWARD:
                        begin
                            sense_next          = (cmd_reg == CMD_FORWARD);
                            dir_next[axis_reg]  = (cmd_reg == CMD_FORWARD);
                            en_next[axis_reg]   = 1'b1;
                            mode_next           = MODE_MOVING;
                        end
                        CMD_STOP:
                        begin
                            en_next   = '0;
                            mode_next = MODE_STOPPED;
                        end
                        CMD_OPEN:         gclosed_next = 1'b0;
                        CMD_CLOSE:        gclosed_next = 1'b1;
                        default:          ;
                    endcase
                end
                FUNC_STEP:
                begin
                    // selected axis only, and only while enabled and moving
                    if (mode_reg == MODE_MOVING && step_axis_reg == axis_reg &&
                        en_reg[axis_reg])
                    begin
                        if (sense_reg)
                            cnt_next[axis_reg] = cnt_reg[axis_reg] + 16'sd1;
                        else
                            cnt_next[axis_reg] = cnt_reg[axis_reg] - 16'sd1;
                    end
                end
                FUNC_LIMIT:
                begin
                    en_next = '0;
                    case (limit_reg)
                        LIM_ELBOW_FRONT:
                        begin
                            cnt_next[AXIS_ELBOW] = {1'b0, elbow_end_reg};
                            dir_next[AXIS_ELBOW] = 1'b0;
                            en_next              = 3'b100;
                        end
                        LIM_ELBOW_REAR:
                        begin
                            cnt_next[AXIS_ELBOW] = '0;
                            dir_next[AXIS_ELBOW] = 1'b1;
                            en_next              = 3'b100;
                        end
                        LIM_SHOULDER_REAR:
                        begin
                            cnt_next[AXIS_SHOULDER] = {1'b0, shoulder_end_reg};
                            dir_next[AXIS_SHOULDER] = 1'b0;
                            en_next                 = 3'b010;
                        end
                        LIM_SHOULDER_FRONT:
                        begin
                            cnt_next[AXIS_SHOULDER] = '0;
                            dir_next[AXIS_SHOULDER] = 1'b1;
                            en_next                 = 3'b010;
                        end
                        LIM_BASE_LEFT:
                        begin
                            cnt_next[AXIS_BASE] = '0;
                            dir_next[AXIS_BASE] = 1'b1;
                            en_next             = 3'b001;
                        end
                        LIM_BASE_RIGHT:
                        begin
                            cnt_next[AXIS_BASE] = {1'b0, base_end_reg};
                            dir_next[AXIS_BASE] = 1'b0;
                            en_next             = 3'b001;
                        end
                        default: ;
                    endcase
                    backoff_next = backoff_len_reg;
                    mode_next    = MODE_BACKOFF;
                    run_pwm      = 1'b0;
                end
                default:
                begin
                    if (gcount_reg != 8'hFF)
                        gcount_next = gcount_reg + 8'd1;
                end
            endcase
        end

        // Gripper pulse: high phase, then low phase, then restart
        hi_ticks = gclosed_next ? closed_high_reg : open_high_reg;
        lo_ticks = gclosed_next ? closed_low_reg  : open_low_reg;
        if (run_pwm)
        begin
            if (!glevel_next && !glow_next)
            begin
                glevel_next = 1'b1;
                gcount_next = '0;
            end
            if (!glow_next && gcount_next >= hi_ticks)
            begin
                glevel_next = 1'b0;
                gcount_next = '0;
                glow_next   = 1'b1;
            end
            if (glow_next && gcount_next >= lo_ticks)
            begin
                glow_next   = 1'b0;
                glevel_next = 1'b1;
                gcount_next = '0;
            end
        end
    end

    // State registers, updated once per applied event
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_STOPPED;
            axis_reg      <= AXIS_BASE;
            sense_reg     <= 1'b0;
            dir_reg       <= '0;
            en_reg        <= '0;
            cnt_reg[0]    <= '0;
            cnt_reg[1]    <= '0;
            cnt_reg[2]    <= '0;
            gclosed_reg   <= 1'b0;
            glevel_reg    <= 1'b0;
            glow_reg      <= 1'b0;
            gcount_reg    <= '0;
            backoff_reg   <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                mode_reg    <= mode_next;
                axis_reg    <= axis_next;
                sense_reg   <= sense_next;
                dir_reg     <= dir_next;
                en_reg      <= en_next;
                cnt_reg     <= cnt_next;
                gclosed_reg <= gclosed_next;
                glevel_reg  <= glevel_next;
                glow_reg    <= glow_next;
                gcount_reg  <= gcount_next;
                backoff_reg <= backoff_next;
            end
        end
    end

    // Status beat
    assign res_out.valid          = out_valid_reg;
    assign res_out.base_dir       = dir_reg[AXIS_BASE];
    assign res_out.dir_shoulder   = dir_reg[AXIS_SHOULDER];
    assign res_out.dir_elbow      = dir_reg[AXIS_ELBOW];
    assign res_out.step_enables   = en_reg;
    assign res_out.base_count     = cnt_reg[AXIS_BASE];
    assign res_out.shoulder_count = cnt_reg[AXIS_SHOULDER];
    assign res_out.elbow_count    = cnt_reg[AXIS_ELBOW];
    assign res_out.gripper_out    = glevel_reg;
    assign res_out.run_mode       = mode_reg;
    assign res_out.chosen_axis    = axis_reg;

endmodule

`default_nettype wire

>>> verif/testbench.sv
`default_nettype none

module testbench;
    import asccu_pkg::*;

    localparam int HANG_LIMIT = 3000;
    localparam int PRINT_CAP  = 50;

    // One status beat as the block drives it
    typedef struct packed {
        logic       base_dir;
        logic       dir_shoulder;
        logic       dir_elbow;
        axis_bits_t step_enables;
        count_t     base_count;
        count_t     shoulder_count;
        count_t     elbow_count;
        logic       gripper_out;
        mode_t      run_mode;
        axis_t      chosen_axis;
    } status_t;

    // Directed stimulus row: either a register write or one event beat
    typedef struct {
        bit          is_cfg;
        logic [2:0]  reg_idx;
        logic [31:0] value;
        func_t       f;
        cmd_t        c;
        axis_t       sa;
        limit_t      lc;
        bit          typed;
        status_t     want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    asccu_in_if  ev_bus ();
    asccu_out_if st_bus ();

    arm_stepper_command_controller_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd_in  (ev_bus),
        .res_out (st_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Arm state as predicted
    mode_t      arm_mode    = MODE_STOPPED;
    axis_t      arm_axis    = AXIS_BASE;
    logic       arm_fwd     = 1'b0;
    axis_bits_t arm_dirs    = '0;
    axis_bits_t arm_enables = '0;
    count_t     arm_counts [3] = '{16'sd0, 16'sd0, 16'sd0};
    logic       grip_closed = 1'b0;
    logic       grip_level  = 1'b0;
    logic       grip_low    = 1'b0;
    logic [7:0] grip_ticks  = '0;
    backoff_t   backoff_left = '0;

    // Register copies
    end_count_t end_counts [3] = '{RST_BASE_END, RST_SHOULDER_END, RST_ELBOW_END};
    pwm_ticks_t open_hi     = RST_OPEN_HIGH;
    pwm_ticks_t open_lo     = RST_OPEN_LOW;
    pwm_ticks_t closed_hi   = RST_CLOSED_HIGH;
    pwm_ticks_t closed_lo   = RST_CLOSED_LOW;
    backoff_t   backoff_len = RST_BACKOFF;

    status_t pending_status [$];
    int      mismatches   = 0;
    int      status_beats = 0;
    bit      calm         = 1'b0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic flag_mismatch(string msg);
        if (mismatches < PRINT_CAP)
            $display("ERROR @%0t: %s", $time, msg);
        mismatches++;
    endtask

    // Apply one event to the predicted arm and return the status it leaves
    function automatic status_t advance_arm(func_t f, cmd_t c, axis_t sa, limit_t lc);
        status_t    s;
        pwm_ticks_t hi;
        pwm_ticks_t lo;
        bit         pulse;
        pulse = 1'b1;
        if (arm_mode == MODE_BACKOFF)
        begin
            // only ticks matter while backing off
            pulse = 1'b0;
            if (f == FUNC_TICK)
            begin
                if (grip_ticks != 8'd255)
                    grip_ticks++;
                if (backoff_left <= 16'd1)
                begin
                    backoff_left = '0;
                    arm_enables  = '0;
                    arm_mode     = MODE_STOPPED;
                    pulse        = 1'b1;
                end
                else
                    backoff_left--;
            end
        end
        else
        begin
            case (f)
                FUNC_CMD:
                begin
                    case (c)
                        CMD_SEL_BASE:     arm_axis = AXIS_BASE;
                        CMD_SEL_SHOULDER: arm_axis = AXIS_SHOULDER;
                        CMD_SEL_ELBOW:    arm_axis = AXIS_ELBOW;
                        CMD_FORWARD, CMD_BACKWARD:
                        begin
                            arm_fwd               = (c == CMD_FORWARD);
                            arm_dirs[arm_axis]    = arm_fwd;
                            arm_enables[arm_axis] = 1'b1;
                            arm_mode              = MODE_MOVING;
                        end
                        CMD_STOP:
                        begin
                            arm_enables = '0;
                            arm_mode    = MODE_STOPPED;
                        end
                        CMD_OPEN:  grip_closed = 1'b0;
                        CMD_CLOSE: grip_closed = 1'b1;
                        default: ;
                    endcase
                end
                FUNC_STEP:
                begin
                    // arm_axis is never 3, so a match also rules out axis 3
                    if (arm_mode == MODE_MOVING && sa == arm_axis && arm_enables[sa])
                        arm_counts[sa] = arm_fwd ? arm_counts[sa] + 16'sd1
                                                 : arm_counts[sa] - 16'sd1;
                end
                FUNC_LIMIT:
                begin
                    pulse       = 1'b0;
                    arm_enables = '0;
                    case (lc)
                        LIM_ELBOW_FRONT:
                        begin
                            arm_counts[AXIS_ELBOW]  = {1'b0, end_counts[AXIS_ELBOW]};
                            arm_dirs[AXIS_ELBOW]    = 1'b0;
                            arm_enables[AXIS_ELBOW] = 1'b1;
                        end
                        LIM_ELBOW_REAR:
                        begin
                            arm_counts[AXIS_ELBOW]  = 16'sd0;
                            arm_dirs[AXIS_ELBOW]    = 1'b1;
                            arm_enables[AXIS_ELBOW] = 1'b1;
                        end
                        LIM_SHOULDER_REAR:
                        begin
                            arm_counts[AXIS_SHOULDER]  = {1'b0, end_counts[AXIS_SHOULDER]};
                            arm_dirs[AXIS_SHOULDER]    = 1'b0;
                            arm_enables[AXIS_SHOULDER] = 1'b1;
                        end
                        LIM_SHOULDER_FRONT:
                        begin
                            arm_counts[AXIS_SHOULDER]  = 16'sd0;
                            arm_dirs[AXIS_SHOULDER]    = 1'b1;
                            arm_enables[AXIS_SHOULDER] = 1'b1;
                        end
                        LIM_BASE_LEFT:
                        begin
                            arm_counts[AXIS_BASE]  = 16'sd0;
                            arm_dirs[AXIS_BASE]    = 1'b1;
                            arm_enables[AXIS_BASE] = 1'b1;
                        end
                        LIM_BASE_RIGHT:
                        begin
                            arm_counts[AXIS_BASE]  = {1'b0, end_counts[AXIS_BASE]};
                            arm_dirs[AXIS_BASE]    = 1'b0;
                            arm_enables[AXIS_BASE] = 1'b1;
                        end
                        default: ;
                    endcase
                    backoff_left = backoff_len;
                    arm_mode     = MODE_BACKOFF;
                end
                default:
                begin
                    if (grip_ticks != 8'd255)
                        grip_ticks++;
                end
            endcase
        end

        // gripper pulse: pending start, high phase, low phase
        if (pulse)
        begin
            hi = grip_closed ? closed_hi : open_hi;
            lo = grip_closed ? closed_lo : open_lo;
            if (!grip_level && !grip_low)
            begin
                grip_level = 1'b1;
                grip_ticks = '0;
            end
            if (!grip_low && grip_ticks >= hi)
            begin
                grip_level = 1'b0;
                grip_ticks = '0;
                grip_low   = 1'b1;
            end
            if (grip_low && grip_ticks >= lo)
            begin
                grip_low   = 1'b0;
                grip_level = 1'b1;
                grip_ticks = '0;
            end
        end

        s.base_dir       = arm_dirs[AXIS_BASE];
        s.dir_shoulder   = arm_dirs[AXIS_SHOULDER];
        s.dir_elbow      = arm_dirs[AXIS_ELBOW];
        s.step_enables   = arm_enables;
        s.base_count     = arm_counts[AXIS_BASE];
        s.shoulder_count = arm_counts[AXIS_SHOULDER];
        s.elbow_count    = arm_counts[AXIS_ELBOW];
        s.gripper_out    = grip_level;
        s.run_mode       = arm_mode;
        s.chosen_axis    = arm_axis;
        return s;
    endfunction

    // Drive one event beat, wait for it to be taken, queue its status
    task automatic send_event(func_t f, cmd_t c, axis_t sa, limit_t lc,
                              bit typed, status_t want);
        status_t predicted;
        int      gap;
        if (!calm && $urandom_range(0, 9) == 0)
        begin
            gap = $urandom_range(1, 14);
            ev_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        ev_bus.valid      <= 1'b1;
        ev_bus.func       <= f;
        ev_bus.cmd_byte   <= c;
        ev_bus.step_axis  <= sa;
        ev_bus.limit_code <= lc;
        do @(posedge clk); while (!ev_bus.ready);
        predicted = advance_arm(f, c, sa, lc);
        pending_status.push_back(typed ? want : predicted);
    endtask

    // Hold off events until every queued status beat has come back
    task automatic wait_drained();
        ev_bus.valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // APB write followed by a read back of the same register
    task automatic write_setting(logic [2:0] idx, logic [31:0] val);
        logic [31:0] back;
        case (idx)
            REG_BASE_END:     end_counts[AXIS_BASE]     = val[14:0];
            REG_SHOULDER_END: end_counts[AXIS_SHOULDER] = val[14:0];
            REG_ELBOW_END:    end_counts[AXIS_ELBOW]    = val[14:0];
            REG_OPEN_HIGH:    open_hi     = val[7:0];
            REG_OPEN_LOW:     open_lo     = val[7:0];
            REG_CLOSED_HIGH:  closed_hi   = val[7:0];
            REG_CLOSED_LOW:   closed_lo   = val[7:0];
            REG_BACKOFF:      backoff_len = val[15:0];
            default: ;
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        back = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (back !== val)
            flag_mismatch($sformatf("register %0d read 0x%0h, wrote 0x%0h", idx, back, val));
    endtask

    task automatic write_all(logic [31:0] base_end, logic [31:0] shoulder_end,
                             logic [31:0] elbow_end, logic [31:0] o_hi,
                             logic [31:0] o_lo, logic [31:0] c_hi,
                             logic [31:0] c_lo, logic [31:0] bo);
        wait_drained();
        write_setting(REG_BASE_END, base_end);
        write_setting(REG_SHOULDER_END, shoulder_end);
        write_setting(REG_ELBOW_END, elbow_end);
        write_setting(REG_OPEN_HIGH, o_hi);
        write_setting(REG_OPEN_LOW, o_lo);
        write_setting(REG_CLOSED_HIGH, c_hi);
        write_setting(REG_CLOSED_LOW, c_lo);
        write_setting(REG_BACKOFF, bo);
    endtask

    // Random arm traffic: mostly selected-axis moves and ticks, some noise.
    // Limit hits are rationed so long back-offs stay few.
    task automatic run_traffic(int n_events, int limit_budget);
        int     sent;
        int     pick;
        func_t  f;
        cmd_t   c;
        axis_t  sa;
        limit_t lc;
        sent = 0;
        while (sent < n_events)
        begin
            f    = func_t'($urandom_range(0, 3));
            c    = cmd_t'($urandom_range(0, 255));
            sa   = axis_t'($urandom_range(0, 3));
            lc   = limit_t'($urandom_range(0, 7));
            pick = $urandom_range(0, 99);
            if (arm_mode == MODE_BACKOFF)
            begin
                if (pick < 85)
                    f = FUNC_TICK;
            end
            else if (pick < 30)
            begin
                f  = FUNC_STEP;
                sa = arm_axis;
            end
            else if (pick < 45)
                f = FUNC_TICK;
            else if (pick < 55)
            begin
                f = FUNC_CMD;
                case ($urandom_range(0, 2))
                    0:       c = CMD_SEL_BASE;
                    1:       c = CMD_SEL_SHOULDER;
                    default: c = CMD_SEL_ELBOW;
                endcase
            end
            else if (pick < 67)
            begin
                f = FUNC_CMD;
                c = $urandom_range(0, 1) ? CMD_FORWARD : CMD_BACKWARD;
            end
            else if (pick < 71)
            begin
                f = FUNC_CMD;
                c = CMD_STOP;
            end
            else if (pick < 77)
            begin
                f = FUNC_CMD;
                c = $urandom_range(0, 1) ? CMD_OPEN : CMD_CLOSE;
            end
            else if (pick < 81)
                f = FUNC_LIMIT;
            else if (pick < 88)
            begin
                // codes around the command range, unknown ones included
                f = FUNC_CMD;
                c = cmd_t'($urandom_range(96, 112));
            end

            if (arm_mode != MODE_BACKOFF)
            begin
                if (f == FUNC_LIMIT)
                begin
                    if (limit_budget == 0)
                        f = FUNC_TICK;
                    else
                        limit_budget--;
                end
                sent++;
            end
            send_event(f, c, sa, lc, 1'b0, '0);
        end
        // tick out any back-off before the next register change
        while (arm_mode == MODE_BACKOFF)
            send_event(FUNC_TICK, cmd_t'($urandom_range(0, 255)), axis_t'($urandom_range(0, 3)),
                       limit_t'($urandom_range(0, 7)), 1'b0, '0);
    endtask

    function automatic row_t ev_row(func_t f, cmd_t c, axis_t sa, limit_t lc);
        row_t r;
        r        = '{f: FUNC_CMD, default: '0};
        r.f      = f;
        r.c      = c;
        r.sa     = sa;
        r.lc     = lc;
        return r;
    endfunction

    function automatic row_t typed_row(func_t f, cmd_t c, axis_t sa, limit_t lc,
                                       status_t want);
        row_t r;
        r       = ev_row(f, c, sa, lc);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic row_t cfg_row(logic [2:0] idx, logic [31:0] val);
        row_t r;
        r         = '{f: FUNC_CMD, default: '0};
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.value   = val;
        return r;
    endfunction

    // Stimulus
    initial
    begin : stimulus
        row_t    plan [$];
        status_t at_reset;

        rst_n             <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        ev_bus.valid      <= 1'b0;
        ev_bus.func       <= FUNC_CMD;
        ev_bus.cmd_byte   <= '0;
        ev_bus.step_axis  <= AXIS_BASE;
        ev_bus.limit_code <= '0;

        // state right after reset once the first pulse period starts
        at_reset             = '0;
        at_reset.gripper_out = 1'b1;

        // unknown codes and a stray step leave the reset state alone
        plan.push_back(typed_row(FUNC_CMD, 8'd0, AXIS_BASE, 3'd0, at_reset));
        plan.push_back(typed_row(FUNC_CMD, 8'd255, AXIS_BASE, 3'd0, at_reset));
        plan.push_back(typed_row(FUNC_STEP, 8'd0, 2'd3, 3'd0, at_reset));
        plan.push_back(ev_row(FUNC_TICK, 8'd0, AXIS_BASE, 3'd0));
        // elbow forward, one counted step, one step for an unselected axis
        plan.push_back(ev_row(FUNC_CMD, CMD_SEL_ELBOW, AXIS_BASE, 3'd0));
        plan.push_back(ev_row(FUNC_CMD, CMD_FORWARD, AXIS_BASE, 3'd0));
        plan.push_back(ev_row(FUNC_STEP, 8'd0, AXIS_ELBOW, 3'd0));
        plan.push_back(ev_row(FUNC_STEP, 8'd0, AXIS_BASE, 3'd0));
        // base backward keeps the elbow enable, count goes below zero
        plan.push_back(ev_row(FUNC_CMD, CMD_SEL_BASE, AXIS_BASE, 3'd0));
        plan.push_back(ev_row(FUNC_CMD, CMD_BACKWARD, AXIS_BASE, 3'd0));
        plan.push_back(ev_row(FUNC_STEP, 8'd0, AXIS_BASE, 3'd0));
        plan.push_back(ev_row(FUNC_STEP, 8'd0, 2'd3, 3'd0));
        plan.push_back(ev_row(FUNC_CMD, CMD_CLOSE, AXIS_BASE, 3'd0));
        plan.push_back(ev_row(FUNC_TICK, 8'd0, AXIS_BASE, 3'd0));
        plan.push_back(ev_row(FUNC_CMD, CMD_OPEN, AXIS_BASE, 3'd0));
        plan.push_back(ev_row(FUNC_CMD, CMD_STOP, AXIS_BASE, 3'd0));
        // zero back-off behaves as one tick; elbow end at its maximum
        plan.push_back(cfg_row(REG_BACKOFF, 32'd0));
        plan.push_back(cfg_row(REG_ELBOW_END, 32'd32767));
        plan.push_back(ev_row(FUNC_LIMIT, 8'd0, AXIS_BASE, LIM_ELBOW_FRONT));
        plan.push_back(ev_row(FUNC_CMD, CMD_FORWARD, AXIS_BASE, 3'd0));
        plan.push_back(ev_row(FUNC_STEP, 8'd0, AXIS_ELBOW, 3'd0));
        plan.push_back(ev_row(FUNC_TICK, 8'd0, AXIS_BASE, 3'd0));
        // elbow from its top count forward wraps to the most negative
        plan.push_back(ev_row(FUNC_CMD, CMD_SEL_ELBOW, AXIS_BASE, 3'd0));
        plan.push_back(ev_row(FUNC_CMD, CMD_FORWARD, AXIS_BASE, 3'd0));
        plan.push_back(ev_row(FUNC_STEP, 8'd0, AXIS_ELBOW, 3'd0));
        // patterns with no axis still back off
        plan.push_back(ev_row(FUNC_LIMIT, 8'd0, AXIS_BASE, 3'd0));
        plan.push_back(ev_row(FUNC_TICK, 8'd0, AXIS_BASE, 3'd0));
        plan.push_back(ev_row(FUNC_LIMIT, 8'd0, AXIS_BASE, 3'd7));
        plan.push_back(ev_row(FUNC_TICK, 8'd0, AXIS_BASE, 3'd0));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                wait_drained();
                write_setting(plan[i].reg_idx, plan[i].value);
            end
            else
                send_event(plan[i].f, plan[i].c, plan[i].sa, plan[i].lc,
                           plan[i].typed, plan[i].want);
        end

        // reset values, limit hits turned into ticks to skip the long back-off
        write_all(32'(RST_BASE_END), 32'(RST_SHOULDER_END), 32'(RST_ELBOW_END),
                  32'(RST_OPEN_HIGH), 32'(RST_OPEN_LOW), 32'(RST_CLOSED_HIGH),
                  32'(RST_CLOSED_LOW), 32'(RST_BACKOFF));
        run_traffic(100, 0);

        // minimum settings
        write_all(0, 0, 0, 1, 1, 1, 1, 1);
        run_traffic(130, 1000);

        // maximum settings
        write_all(32767, 32767, 32767, 255, 255, 255, 255, 65535);
        run_traffic(60, 0);

        // widest pulse times; one long back-off saturates the tick count
        write_all(32767, 32767, 32767, 255, 255, 255, 255, 260);
        run_traffic(40, 0);
        send_event(FUNC_LIMIT, 8'd0, AXIS_BASE, LIM_BASE_RIGHT, 1'b0, '0);
        run_traffic(0, 0);

        write_all($urandom_range(0, 32767), $urandom_range(0, 32767),
                  $urandom_range(0, 32767), $urandom_range(1, 255),
                  $urandom_range(1, 255), $urandom_range(1, 255),
                  $urandom_range(1, 255), $urandom_range(1, 40));
        run_traffic(100, 1000);

        write_all($urandom_range(0, 32767), $urandom_range(0, 32767),
                  $urandom_range(0, 32767), $urandom_range(1, 6),
                  $urandom_range(1, 6), $urandom_range(1, 6),
                  $urandom_range(1, 6), $urandom_range(1, 20));
        run_traffic(100, 1000);

        // final stretch runs with no idling on either side
        write_all($urandom_range(0, 32767), $urandom_range(0, 32767),
                  $urandom_range(0, 32767), $urandom_range(1, 4),
                  $urandom_range(1, 4), $urandom_range(1, 4),
                  $urandom_range(1, 4), $urandom_range(1, 8));
        calm = 1'b1;
        run_traffic(100, 1000);

        wait_drained();
        repeat (4) @(posedge clk);
        if (pending_status.size() != 0)
            flag_mismatch($sformatf("%0d status beats never arrived", pending_status.size()));
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Status sink with random stall bursts
    initial
    begin : status_sink
        int stall_left;
        stall_left = 0;
        st_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left == 0 && !calm && $urandom_range(0, 11) == 0)
                stall_left = $urandom_range(1, 14);
            if (stall_left != 0)
            begin
                st_bus.ready <= 1'b0;
                stall_left--;
            end
            else
                st_bus.ready <= 1'b1;
        end
    end

    // Compare each status beat against the oldest expectation
    always @(posedge clk)
    begin : status_check
        status_t got;
        status_t want;
        if (rst_n && st_bus.valid && st_bus.ready)
        begin
            got.base_dir       = st_bus.base_dir;
            got.dir_shoulder   = st_bus.dir_shoulder;
            got.dir_elbow      = st_bus.dir_elbow;
            got.step_enables   = st_bus.step_enables;
            got.base_count     = st_bus.base_count;
            got.shoulder_count = st_bus.shoulder_count;
            got.elbow_count    = st_bus.elbow_count;
            got.gripper_out    = st_bus.gripper_out;
            got.run_mode       = st_bus.run_mode;
            got.chosen_axis    = st_bus.chosen_axis;
            if (pending_status.size() == 0)
                flag_mismatch($sformatf("status beat %0d with nothing expected", status_beats));
            else
            begin
                want = pending_status.pop_front();
                if (got.base_dir !== want.base_dir)
                    flag_mismatch($sformatf("beat %0d base_dir %0d, want %0d",
                                            status_beats, got.base_dir, want.base_dir));
                if (got.dir_shoulder !== want.dir_shoulder)
                    flag_mismatch($sformatf("beat %0d dir_shoulder %0d, want %0d",
                                            status_beats, got.dir_shoulder, want.dir_shoulder));
                if (got.dir_elbow !== want.dir_elbow)
                    flag_mismatch($sformatf("beat %0d dir_elbow %0d, want %0d",
                                            status_beats, got.dir_elbow, want.dir_elbow));
                if (got.step_enables !== want.step_enables)
                    flag_mismatch($sformatf("beat %0d step_enables %b, want %b",
                                            status_beats, got.step_enables, want.step_enables));
                if (got.base_count !== want.base_count)
                    flag_mismatch($sformatf("beat %0d base_count %0d, want %0d",
                                            status_beats, got.base_count, want.base_count));
                if (got.shoulder_count !== want.shoulder_count)
                    flag_mismatch($sformatf("beat %0d shoulder_count %0d, want %0d", status_beats,
                                            got.shoulder_count, want.shoulder_count));
                if (got.elbow_count !== want.elbow_count)
                    flag_mismatch($sformatf("beat %0d elbow_count %0d, want %0d",
                                            status_beats, got.elbow_count, want.elbow_count));
                if (got.gripper_out !== want.gripper_out)
                    flag_mismatch($sformatf("beat %0d gripper_out %0d, want %0d",
                                            status_beats, got.gripper_out, want.gripper_out));
                if (got.run_mode !== want.run_mode)
                    flag_mismatch($sformatf("beat %0d run_mode %0d, want %0d",
                                            status_beats, got.run_mode, want.run_mode));
                if (got.chosen_axis !== want.chosen_axis)
                    flag_mismatch($sformatf("beat %0d chosen_axis %0d, want %0d",
                                            status_beats, got.chosen_axis, want.chosen_axis));
            end
            status_beats++;
        end
    end

    // Hang guard: too many cycles with no beat taken on either side
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < HANG_LIMIT)
        begin
            @(posedge clk);
            if ((ev_bus.valid && ev_bus.ready) || (st_bus.valid && st_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Timeout: no beat taken for %0d cycles", HANG_LIMIT);
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
